// File: hw/rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constant tables for the extended Hamming (64,56) codec.
// ----------------------------------------------------------------------------
package ehc_pkg;

  localparam int CODE_W   = 64;
  localparam int DATA_W   = 56;
  localparam int DATA_BITS = 56;
  localparam int CHK_BITS = 6;
  localparam int PAR_N    = CHK_BITS + 1;  // six check bits plus overall parity
  localparam int HALF_W   = CODE_W / 2;
  localparam int POS_W    = $clog2(CODE_W);

  typedef enum logic {
    OP_ENCODE  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] code;
  } in_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] data;
  } map_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] data;
    logic [PAR_N-1:0]  lo;
    logic [PAR_N-1:0]  hi;
  } par_t;

  function automatic logic is_reserved(input int p);
    return (p == 0) || (p == 1) || (p == 2) || (p == 4) || (p == 8) ||
           (p == 16) || (p == 32);
  endfunction

  // codeword position of each data bit, first data bit at index 0
  function automatic logic [DATA_BITS-1:0][POS_W-1:0] dat_positions();
    logic [DATA_BITS-1:0][POS_W-1:0] r;
    int i;
    r = '0;
    i = 0;
    for (int p = 0; p < CODE_W; p++) begin
      if (!is_reserved(p) && i < DATA_BITS) begin
        r[i] = POS_W'(p);
        i++;
      end
    end
    return r;
  endfunction

  // mask over codeword bits (position p is bit CODE_W-1-p); entry CHK_BITS
  // covers every position for the overall parity
  function automatic logic [PAR_N-1:0][CODE_W-1:0] chk_masks();
    logic [PAR_N-1:0][CODE_W-1:0] r;
    r = '0;
    for (int k = 0; k < PAR_N; k++) begin
      for (int p = 0; p < CODE_W; p++) begin
        if (k == CHK_BITS || ((p >> k) & 1) == 1) begin
          r[k][CODE_W-1-p] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  localparam logic [DATA_BITS-1:0][POS_W-1:0] DAT_POS  = dat_positions();
  localparam logic [PAR_N-1:0][CODE_W-1:0]    CHK_MASK = chk_masks();

endpackage

// File: hw/rtl/ehc_map.sv
// ----------------------------------------------------------------------------
// ehc_map
// Input register and bit permutation stage: scatters data bits into codeword
// positions for encode, gathers them back out for extract.
// ----------------------------------------------------------------------------
module ehc_map (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ehc_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output ehc_pkg::map_t out_word
);
  import ehc_pkg::*;

  logic v1;
  logic v2;
  logic r1;
  logic r2;
  in_t  s1;
  map_t s2;
  map_t s2_next;

  assign r2 = !v2 || out_ready;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    s2_next = '0;
    s2_next.op = s1.op;
    for (int i = 0; i < DATA_BITS; i++) begin
      // position p sits at bit 63-p, which is ~p on six bits
      if (s1.op == OP_ENCODE) begin
        s2_next.code[~DAT_POS[i]] = s1.data[DATA_W-1-i];
      end else begin
        s2_next.data[DATA_W-1-i] = s1.code[~DAT_POS[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1 <= in_word;
    end
    if (r2 && v1) begin
      s2 <= s2_next;
    end
  end

  assign out_valid = v2;
  assign out_word  = s2;

  a_extract_no_code: assert property (@(posedge clk) disable iff (rst)
    v2 && s2.op == OP_EXTRACT |-> s2.code == '0)
    else $error("extract word carries codeword bits");

  a_encode_no_data: assert property (@(posedge clk) disable iff (rst)
    v2 && s2.op == OP_ENCODE |-> s2.data == '0)
    else $error("encode word carries data bits");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted word not held in first stage");

endmodule

// File: hw/rtl/ehc_par.sv
// ----------------------------------------------------------------------------
// ehc_par
// Parity stages: half-word partial parities, then check bit insertion into
// the output register.
// ----------------------------------------------------------------------------
module ehc_par (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ehc_pkg::map_t              in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ehc_pkg::CODE_W-1:0] code_out,
  output logic [ehc_pkg::DATA_W-1:0] data_out
);
  import ehc_pkg::*;

  logic              v3;
  logic              v4;
  logic              r3;
  logic              r4;
  par_t              s3;
  par_t              s3_next;
  op_t               op4;
  logic [CODE_W-1:0] code4;
  logic [CODE_W-1:0] code4_next;
  logic [DATA_W-1:0] data4;
  logic [CHK_BITS-1:0] syn;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign in_ready = r3;

  always_comb begin
    s3_next = '0;
    s3_next.op   = in_word.op;
    s3_next.code = in_word.code;
    s3_next.data = in_word.data;
    for (int k = 0; k < PAR_N; k++) begin
      s3_next.lo[k] = ^(in_word.code[CODE_W-1:HALF_W] & CHK_MASK[k][CODE_W-1:HALF_W]);
      s3_next.hi[k] = ^(in_word.code[HALF_W-1:0] & CHK_MASK[k][HALF_W-1:0]);
    end
  end

  // overall parity covers data only, so it is taken before checks go in
  always_comb begin
    code4_next = s3.code;
    for (int k = 0; k < CHK_BITS; k++) begin
      code4_next[CODE_W-1-(1 << k)] = s3.lo[k] ^ s3.hi[k];
    end
    code4_next[CODE_W-1] = s3.lo[CHK_BITS] ^ s3.hi[CHK_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r3) begin
        v3 <= in_valid;
      end
      if (r4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && in_valid) begin
      s3 <= s3_next;
    end
    if (r4 && v3) begin
      op4   <= s3.op;
      code4 <= code4_next;
      data4 <= s3.data;
    end
  end

  assign out_valid = v4;
  assign code_out  = code4;
  assign data_out  = data4;

  always_comb begin
    for (int k = 0; k < CHK_BITS; k++) begin
      syn[k] = ^(code4 & CHK_MASK[k]);
    end
  end

  a_encode_syndrome: assert property (@(posedge clk) disable iff (rst)
    v4 && op4 == OP_ENCODE |-> syn == '0)
    else $error("encoded word has nonzero syndrome");

  a_one_side_zero: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (code4 == '0 || data4 == '0))
    else $error("both result fields nonzero");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v3 && r4 |=> v4)
    else $error("word lost between parity stages");

endmodule

// File: hw/rtl/extended_hamming_64_56_codec_top.sv
// ----------------------------------------------------------------------------
// extended_hamming_64_56_codec_top
// Extended Hamming (64,56) encoder and data extractor on stream ports.
// ----------------------------------------------------------------------------
// Pipeline: four register stages, two in ehc_map and two in ehc_par.
// Throughput: one word per cycle; the pipeline stalls stage by stage on
// m_axis_tready, each stage refilling as soon as its successor moves.
// Reset (rst, synchronous): clears all stage valid bits; no other state.
module extended_hamming_64_56_codec_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // data_in[55:0], code_in[119:56], zero pad
  input  logic [0:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // code_out[63:0], data_out[119:64], zero pad
);
  import ehc_pkg::*;

  in_t               in_word;
  map_t              map_word;
  logic              map_valid;
  logic              map_ready;
  logic [CODE_W-1:0] code_out;
  logic [DATA_W-1:0] data_out;

  assign in_word.op   = op_t'(s_axis_tuser[0]);
  assign in_word.data = s_axis_tdata[DATA_W-1:0];
  assign in_word.code = s_axis_tdata[DATA_W+CODE_W-1:DATA_W];

  ehc_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_word   (in_word),
    .out_valid (map_valid),
    .out_ready (map_ready),
    .out_word  (map_word)
  );

  ehc_par u_par (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (map_valid),
    .in_ready  (map_ready),
    .in_word   (map_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .code_out  (code_out),
    .data_out  (data_out)
  );

  assign m_axis_tdata = {8'b0, data_out, code_out};

endmodule
